FILE: hdl/lgs_pkg.sv
package lgs_pkg;

  // Widths of the word fields.
  localparam int LLR_WIDTH = 16;
  localparam int LFSR_WIDTH = 31;

  // Sequence warm-up before the first bit of a codeword.
  localparam int WARMUP_STEPS = 1600;
  localparam int WARM_CHUNK = 8;
  localparam int CNT_WIDTH = $clog2(WARMUP_STEPS + 1) > 0 ? $clog2(WARMUP_STEPS + 1) : 1;

  // Input queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // Configuration port.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 16;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RNTI = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CODEWORD_INDEX = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SLOT_NUMBER = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CELL_ID = 3'd4;

  // Mode codes.
  localparam logic MODE_SCRAMBLE = 1'b0;
  localparam logic MODE_DESCRAMBLE = 1'b1;

  typedef struct packed {
    logic signed [LLR_WIDTH-1:0] sample;
    logic                        last_item;
  } item_t;

  typedef struct packed {
    logic signed [LLR_WIDTH-1:0] value;
    logic                        last;
  } result_t;

  // Queue entry: the word plus the front's first-of-codeword mark.
  typedef struct packed {
    item_t item;
    logic  first;
  } entry_t;

  typedef struct packed {
    logic                  mode;
    logic [LFSR_WIDTH-1:0] seed;
  } cfg_t;

  typedef struct packed {
    logic [LFSR_WIDTH-1:0] x1;
    logic [LFSR_WIDTH-1:0] x2;
  } lfsr_t;

  // One step of both Gold sequence registers.
  function automatic lfsr_t lfsr_step(lfsr_t s);
    lfsr_t r;
    r.x1 = {s.x1[0] ^ s.x1[3], s.x1[LFSR_WIDTH-1:1]};
    r.x2 = {s.x2[0] ^ s.x2[1] ^ s.x2[2] ^ s.x2[3], s.x2[LFSR_WIDTH-1:1]};
    return r;
  endfunction

  // A chunk of steps in one go, used during warm-up.
  function automatic lfsr_t lfsr_chunk(lfsr_t s);
    lfsr_t r;
    r = s;
    for (int k = 0; k < WARM_CHUNK; k++) begin
      r = lfsr_step(r);
    end
    return r;
  endfunction

endpackage

FILE: hdl/lgs_front.sv
module lgs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_stall,
  input  lgs_pkg::item_t item,
  output logic           q_valid,
  output lgs_pkg::entry_t q_entry,
  input  logic           q_pop
);

  lgs_pkg::entry_t mem [lgs_pkg::QUEUE_DEPTH];
  logic [lgs_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [lgs_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [lgs_pkg::QUEUE_AW:0]   count;
  logic                         at_start;
  logic                         push;
  logic                         pop;

  // Full queue holds the input side.
  assign item_stall = (count == (lgs_pkg::QUEUE_AW + 1)'(lgs_pkg::QUEUE_DEPTH));
  assign push = item_valid && !item_stall;
  assign pop = q_pop && q_valid;

  assign q_valid = (count != '0);
  assign q_entry = mem[rd_ptr];

  // Mark each word that opens a codeword and store it.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr].item <= item;
      mem[wr_ptr].first <= at_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
      at_start <= 1'b1;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
        at_start <= item.last_item;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/lgs_back.sv
module lgs_back (
  input  logic             clk,
  input  logic             rst,
  input  lgs_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  lgs_pkg::entry_t  q_entry,
  output logic             q_pop,
  output logic             result_valid,
  input  logic             result_stall,
  output lgs_pkg::result_t result
);

  localparam logic ST_RUN = 1'b0;
  localparam logic ST_WARM = 1'b1;
  localparam logic signed [lgs_pkg::LLR_WIDTH-1:0] LLR_MIN =
    {1'b1, {(lgs_pkg::LLR_WIDTH-1){1'b0}}};
  localparam logic signed [lgs_pkg::LLR_WIDTH-1:0] LLR_MAX =
    {1'b0, {(lgs_pkg::LLR_WIDTH-1){1'b1}}};

  logic [0:0]                     state;
  logic [0:0]                     state_next;
  logic                           warm_done;
  logic                           warm_done_next;
  logic [lgs_pkg::CNT_WIDTH-1:0]  cnt;
  logic [lgs_pkg::CNT_WIDTH-1:0]  cnt_next;
  lgs_pkg::lfsr_t                 lfsr;
  lgs_pkg::lfsr_t                 lfsr_next;
  logic                           out_free;
  logic                           load_out;
  logic                           c_bit;
  logic signed [lgs_pkg::LLR_WIDTH-1:0] value_calc;

  assign out_free = !result_valid || !result_stall;
  assign c_bit = lfsr.x1[0] ^ lfsr.x2[0];

  // Scramble or descramble the head word with the current sequence bit.
  always_comb begin
    if (cfg.mode == lgs_pkg::MODE_SCRAMBLE) begin
      value_calc = {{(lgs_pkg::LLR_WIDTH-1){1'b0}}, q_entry.item.sample[0] ^ c_bit};
    end else if (c_bit) begin
      value_calc = q_entry.item.sample;
    end else if (q_entry.item.sample == LLR_MIN) begin
      value_calc = LLR_MAX;
    end else begin
      value_calc = -q_entry.item.sample;
    end
  end

  // Sequencer: warm up at a codeword start, then one word per cycle while the output is not stalled.
  always_comb begin
    state_next = state;
    warm_done_next = warm_done;
    cnt_next = cnt;
    lfsr_next = lfsr;
    q_pop = 1'b0;
    load_out = 1'b0;
    case (state)
      ST_RUN: begin
        if (q_valid && q_entry.first && !warm_done) begin
          lfsr_next.x1 = lgs_pkg::LFSR_WIDTH'(1);
          lfsr_next.x2 = cfg.seed;
          cnt_next = lgs_pkg::CNT_WIDTH'(lgs_pkg::WARMUP_STEPS);
          state_next = ST_WARM;
        end else if (q_valid && out_free) begin
          q_pop = 1'b1;
          load_out = 1'b1;
          lfsr_next = lgs_pkg::lfsr_step(lfsr);
          warm_done_next = 1'b0;
        end
      end
      ST_WARM: begin
        if (cnt >= lgs_pkg::CNT_WIDTH'(lgs_pkg::WARM_CHUNK)) begin
          lfsr_next = lgs_pkg::lfsr_chunk(lfsr);
          cnt_next = cnt - lgs_pkg::CNT_WIDTH'(lgs_pkg::WARM_CHUNK);
        end else if (cnt != '0) begin
          lfsr_next = lgs_pkg::lfsr_step(lfsr);
          cnt_next = cnt - 1'b1;
        end else begin
          warm_done_next = 1'b1;
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      warm_done <= 1'b0;
      cnt <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      warm_done <= warm_done_next;
      cnt <= cnt_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Sequence registers and the output word carry data only.
  always_ff @(posedge clk) begin
    lfsr <= lfsr_next;
    if (load_out) begin
      result.value <= value_calc;
      result.last <= q_entry.item.last_item;
    end
  end

endmodule

FILE: hdl/lte_gold_sequence_scrambler_core.sv
// Scrambles hard bits or descrambles soft LLRs of one LTE codeword with the
// length-31 Gold sequence seeded from rnti, codeword_index, slot_number and
// cell_id. Within a codeword one word is taken and one result given per
// cycle while the output is not stalled. The first word of each codeword
// waits for the sequence warm-up: 1600 register steps done eight per cycle
// in the step logic of the sequence generator. A four-word input queue
// keeps accepting, until it is full, during that time and while a result
// waits on the output. The seed is read when a codeword starts and mode is
// read per word; write configuration only while the block is idle.
module lte_gold_sequence_scrambler_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  lgs_pkg::item_t                      item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output lgs_pkg::result_t                    result,
  input  logic                                cfg_write,
  input  logic [lgs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lgs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  logic        mode;
  logic [15:0] rnti;
  logic        codeword_index;
  logic [4:0]  slot_number;
  logic [8:0]  cell_id;

  lgs_pkg::cfg_t   cfg;
  logic            q_valid;
  lgs_pkg::entry_t q_entry;
  logic            q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= lgs_pkg::MODE_SCRAMBLE;
      rnti <= '0;
      codeword_index <= 1'b0;
      slot_number <= '0;
      cell_id <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        lgs_pkg::REG_MODE: mode <= cfg_data[0];
        lgs_pkg::REG_RNTI: rnti <= cfg_data[15:0];
        lgs_pkg::REG_CODEWORD_INDEX: codeword_index <= cfg_data[0];
        lgs_pkg::REG_SLOT_NUMBER: slot_number <= cfg_data[4:0];
        lgs_pkg::REG_CELL_ID: cell_id <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // The seed fields do not overlap, so the sum is a concatenation.
  assign cfg.mode = mode;
  assign cfg.seed = {1'b0, rnti, codeword_index, slot_number[4:1], cell_id};

  lgs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop)
  );

  lgs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_entry      (q_entry),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 205;
  localparam logic signed [lgs_pkg::LLR_WIDTH-1:0] LLR_MIN =
    {1'b1, {(lgs_pkg::LLR_WIDTH-1){1'b0}}};
  localparam logic signed [lgs_pkg::LLR_WIDTH-1:0] LLR_MAX =
    {1'b0, {(lgs_pkg::LLR_WIDTH-1){1'b1}}};

  // Predicts each result of the scrambler and checks what comes out in order.
  class scrambler_scoreboard;
    logic                           mode;
    logic [15:0]                    rnti;
    logic                           cw_index;
    logic [4:0]                     slot;
    logic [8:0]                     cell_id;
    logic [lgs_pkg::LFSR_WIDTH-1:0] x1;
    logic [lgs_pkg::LFSR_WIDTH-1:0] x2;
    logic [31:0]                    seq_word;
    logic [4:0]                     bit_pos;
    logic                           cw_start;
    lgs_pkg::result_t               expected_q[$];
    int                             errors;

    function new();
      mode     = lgs_pkg::MODE_SCRAMBLE;
      rnti     = '0;
      cw_index = 1'b0;
      slot     = '0;
      cell_id  = '0;
      x1       = lgs_pkg::LFSR_WIDTH'(1);
      x2       = '0;
      seq_word = '0;
      bit_pos  = '0;
      cw_start = 1'b1;
      errors   = 0;
    endfunction

    function void set_reg(logic [lgs_pkg::CFG_INDEX_WIDTH-1:0] idx,
                          logic [lgs_pkg::CFG_DATA_WIDTH-1:0] d);
      case (idx)
        lgs_pkg::REG_MODE:           mode = d[0];
        lgs_pkg::REG_RNTI:           rnti = d[15:0];
        lgs_pkg::REG_CODEWORD_INDEX: cw_index = d[0];
        lgs_pkg::REG_SLOT_NUMBER:    slot = d[4:0];
        lgs_pkg::REG_CELL_ID:        cell_id = d[8:0];
        default: ;
      endcase
    endfunction

    // One shift of both Gold sequence registers.
    function void step_lfsrs();
      logic fb1;
      logic fb2;
      fb1 = x1[0] ^ x1[3];
      fb2 = x2[0] ^ x2[1] ^ x2[2] ^ x2[3];
      x1 = {fb1, x1[lgs_pkg::LFSR_WIDTH-1:1]};
      x2 = {fb2, x2[lgs_pkg::LFSR_WIDTH-1:1]};
    endfunction

    // The next 32 bits of c(n), oldest bit in bit 0.
    function void fill_seq_word();
      for (int k = 0; k < 32; k++) begin
        seq_word[k] = x1[0] ^ x2[0];
        step_lfsrs();
      end
    endfunction

    // Works out the result of one word and moves the sequence on.
    function lgs_pkg::result_t scramble_word(lgs_pkg::item_t w);
      lgs_pkg::result_t r;
      logic c;
      logic signed [lgs_pkg::LLR_WIDTH-1:0] v;
      int unsigned seed;
      // The seed is taken from the registers only at the start of a codeword.
      if (cw_start) begin
        seed = (int'(rnti) << 14) + (int'(cw_index) << 13) + ((int'(slot) >> 1) << 9)
               + int'(cell_id);
        x1 = lgs_pkg::LFSR_WIDTH'(1);
        x2 = seed[lgs_pkg::LFSR_WIDTH-1:0];
        repeat (lgs_pkg::WARMUP_STEPS) step_lfsrs();
        bit_pos = '0;
        cw_start = 1'b0;
      end
      if (bit_pos == 0) begin
        fill_seq_word();
      end
      c = seq_word[bit_pos];
      if (mode == lgs_pkg::MODE_SCRAMBLE) begin
        r.value = '0;
        r.value[0] = w.sample[0] ^ c;
      end else begin
        v = w.sample;
        if (!c) begin
          v = (v == LLR_MIN) ? LLR_MAX : -v;
        end
        r.value = v;
      end
      r.last = w.last_item;
      bit_pos = bit_pos + 5'd1;
      if (w.last_item) begin
        cw_start = 1'b1;
        bit_pos = '0;
      end
      return r;
    endfunction

    function void note_word(lgs_pkg::item_t w);
      expected_q.push_back(scramble_word(w));
    endfunction

    function void check_result(lgs_pkg::result_t got);
      lgs_pkg::result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, got value %0d last %0b",
                 $time, got.value, got.last);
      end else begin
        want = expected_q.pop_front();
        if (got.value !== want.value) begin
          errors++;
          $display("%0t: value mismatch, expected %0d, got %0d", $time, want.value, got.value);
        end
        if (got.last !== want.last) begin
          errors++;
          $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, got.last);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                item_valid = 1'b0;
  logic                                item_stall;
  lgs_pkg::item_t                      item = '0;
  logic                                result_valid;
  logic                                result_stall = 1'b1;
  lgs_pkg::result_t                    result;
  logic                                cfg_write = 1'b0;
  logic [lgs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = lgs_pkg::REG_MODE;
  logic [lgs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  scrambler_scoreboard sb = new();
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int cw_left = 0;

  lte_gold_sequence_scrambler_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Offers one word, with an occasional gap first, and waits until it is taken.
  task automatic send_word(input lgs_pkg::item_t w);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    item <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_word(w);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [lgs_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [lgs_pkg::CFG_DATA_WIDTH-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.set_reg(idx, d);
  endtask

  task automatic configure(input logic m, input logic [15:0] r, input logic q,
                           input logic [4:0] s, input logic [8:0] c);
    write_reg(lgs_pkg::REG_MODE, lgs_pkg::CFG_DATA_WIDTH'(m));
    write_reg(lgs_pkg::REG_RNTI, lgs_pkg::CFG_DATA_WIDTH'(r));
    write_reg(lgs_pkg::REG_CODEWORD_INDEX, lgs_pkg::CFG_DATA_WIDTH'(q));
    write_reg(lgs_pkg::REG_SLOT_NUMBER, lgs_pkg::CFG_DATA_WIDTH'(s));
    write_reg(lgs_pkg::REG_CELL_ID, lgs_pkg::CFG_DATA_WIDTH'(c));
    cfg_write <= 1'b0;
  endtask

  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Mostly random samples, with the saturation corner and the all-ones and
  // all-zeros words thrown in often.
  function automatic lgs_pkg::item_t make_word(input logic last_flag);
    lgs_pkg::item_t w;
    case ($urandom_range(0, 15))
      0:       w.sample = LLR_MIN;
      1:       w.sample = LLR_MAX;
      2:       w.sample = '0;
      3:       w.sample = '1;
      default: w.sample = lgs_pkg::LLR_WIDTH'($urandom);
    endcase
    w.last_item = last_flag;
    return w;
  endfunction

  // Codeword lengths: mostly short, some past one sequence word, a few of a single word.
  function automatic int pick_length();
    case ($urandom_range(0, 9))
      0:       return 1;
      1, 2:    return $urandom_range(41, 100);
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  // Result side: checks every accepted word and stalls in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        sb.check_result(result);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left != 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus: directed words first, then random phases under varied settings.
  initial begin
    logic m;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, scramble mode: bit 0 both ways, upper bits ignored, and a
    // codeword of a single word.
    send_word(lgs_pkg::item_t'{16'sh0000, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh0001, 1'b0});
    send_word(lgs_pkg::item_t'{16'shFFFE, 1'b0});
    send_word(lgs_pkg::item_t'{16'shFFFF, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh8000, 1'b1});
    send_word(lgs_pkg::item_t'{16'sh7FFF, 1'b1});
    item_valid <= 1'b0;
    wait_idle();

    // Largest seed fields, out of range slot and cell, descrambling the LLR
    // extremes; the most negative value appears often enough to meet c = 0.
    configure(lgs_pkg::MODE_DESCRAMBLE, 16'hFFFF, 1'b1, 5'd31, 9'd511);
    send_word(lgs_pkg::item_t'{16'sh8000, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh7FFF, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh0000, 1'b0});
    send_word(lgs_pkg::item_t'{16'shFFFF, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh0001, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh8000, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh8000, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh8000, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh8000, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh7FFF, 1'b0});
    item_valid <= 1'b0;
    wait_idle();

    // Mode and seed change inside an open codeword: the mode applies at once,
    // the seed only from the next codeword.
    configure(lgs_pkg::MODE_SCRAMBLE, 16'h0000, 1'b0, 5'd0, 9'd0);
    send_word(lgs_pkg::item_t'{16'sh0001, 1'b0});
    send_word(lgs_pkg::item_t'{16'sh0000, 1'b0});
    send_word(lgs_pkg::item_t'{16'shFFFF, 1'b1});
    send_word(lgs_pkg::item_t'{16'sh0001, 1'b1});
    item_valid <= 1'b0;
    wait_idle();

    // Random phases; a phase may end with its codeword still open.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      quiet = (p == RANDOM_PHASES - 1);
      m = (p == RANDOM_PHASES - 1) ? logic'($urandom_range(0, 1)) : logic'(p % 2);
      case (p)
        1: configure(m, 16'h0000, 1'b0, 5'd0, 9'd0);
        3: configure(m, 16'hFFFF, 1'b1, 5'd31, 9'd511);
        default: configure(m, 16'($urandom), logic'($urandom_range(0, 1)),
                           5'($urandom_range(0, 31)), 9'($urandom_range(0, 511)));
      endcase
      // The result side holds off long enough for the input queue to fill.
      if (p == 2) begin
        hold_req = 1'b1;
      end
      repeat (WORDS_PER_PHASE) begin
        if (cw_left == 0) begin
          cw_left = pick_length();
        end
        send_word(make_word(cw_left == 1));
        cw_left--;
      end
      item_valid <= 1'b0;
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
